[hdl/bmdph_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bmdph_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_CHANNELS = 8;
    localparam int DEF_SEGMENTS = 12;

    // Field widths.
    localparam int LVL_W     = 13;
    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int STEP_W    = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_BITS = 12;

    // Level arithmetic; 4096 is full scale.
    localparam logic [LVL_W-1:0] FULL_SCALE  = 13'd4096;
    localparam logic [LVL_W-1:0] CLEAR_BELOW = 13'd41;
    localparam logic [LVL_W:0]   PEAK_MARGIN = 14'd4;
    localparam int               ROUND_HALF  = 2048;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP     = 2'd2;

    // Register values after reset.
    localparam logic [MS_W-1:0]   DEF_DECAY_INTERVAL = 16'd100;
    localparam logic [MS_W-1:0]   DEF_PEAK_HOLD      = 16'd2000;
    localparam logic [STEP_W-1:0] DEF_DECAY_STEP     = 13'd341;

    // Input opcodes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick_start;  // latch the tick time, clear the change flag
        logic lvl_wr;      // store a written level and its time
        logic rd_en;       // read one channel's state into the read register
        logic upd_wr;      // write back the updated state of the channel read
        logic out_ld;      // load one display result into the output register
    } t_cmd;

endpackage

`default_nettype wire

[hdl/bmdph_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmdph_ctrl #(
    parameter int CHANNELS = bmdph_pkg::DEF_CHANNELS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_opcode,
    output logic                   o_in_stall,
    input  wire                    i_out_free,
    output bmdph_pkg::t_cmd        o_cmd,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] o_idx
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_URD  = 3'd1;
    localparam logic [2:0] S_UWR  = 3'd2;
    localparam logic [2:0] S_ORD  = 3'd3;
    localparam logic [2:0] S_OLD  = 3'd4;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic [CH_W-1:0] r_idx;
    logic [CH_W-1:0] n_idx;
    logic            w_last;

    assign w_last     = (r_idx == CH_W'(CHANNELS - 1));
    assign o_in_stall = (r_state != S_IDLE);
    assign o_idx      = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == bmdph_pkg::OP_TICK) begin
                        o_cmd.tick_start = 1'b1;
                        n_idx            = '0;
                        n_state          = S_URD;
                    end else begin
                        o_cmd.lvl_wr = 1'b1;
                    end
                end
            end
            S_URD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_UWR;
            end
            S_UWR: begin
                o_cmd.upd_wr = 1'b1;
                if (w_last) begin
                    n_idx   = '0;
                    n_state = S_ORD;
                end else begin
                    n_idx   = r_idx + CH_W'(1);
                    n_state = S_URD;
                end
            end
            S_ORD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_OLD;
            end
            S_OLD: begin
                if (i_out_free) begin
                    o_cmd.out_ld = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CH_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command in a cycle");

    a_out_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_out_free)
        else $error("result loaded while the output register is still held");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd_wr |-> $past(o_cmd.rd_en))
        else $error("write-back without a preceding read");

    a_tick_begins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tick_start |=> (r_state == S_URD) && (r_idx == '0))
        else $error("tick did not start its update pass at the first channel");
`endif

endmodule

`default_nettype wire

[hdl/bmdph_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmdph_dp #(
    parameter int CHANNELS = bmdph_pkg::DEF_CHANNELS,
    parameter int SEGMENTS = bmdph_pkg::DEF_SEGMENTS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  bmdph_pkg::t_cmd                       i_cmd,
    input  wire [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_idx,
    input  wire                                   i_cfg_wr_en,
    input  wire [bmdph_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [bmdph_pkg::CFG_W-1:0]            i_cfg_data,
    input  wire [bmdph_pkg::TIME_W-1:0]           i_time_ms,
    input  wire [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_channel,
    input  wire [bmdph_pkg::LVL_W-1:0]            i_level_in,
    output logic                                  o_out_free,
    input  wire                                   i_out_stall,
    output logic                                  o_out_valid,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] o_out_channel,
    output logic [SEGMENTS-1:0]                   o_lit_mask,
    output logic                                  o_peak_valid,
    output logic [$clog2(SEGMENTS)-1:0]           o_peak_segment,
    output logic                                  o_changed,
    output logic                                  o_last
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SEG_W  = $clog2(SEGMENTS);
    localparam int LVL_W  = bmdph_pkg::LVL_W;
    localparam int TIME_W = bmdph_pkg::TIME_W;
    localparam int MS_W   = bmdph_pkg::MS_W;
    localparam int STEP_W = bmdph_pkg::STEP_W;
    localparam int PROD_W = LVL_W + $clog2(SEGMENTS + 1);
    localparam int ACT_W  = PROD_W - bmdph_pkg::FRAC_BITS;

    // Configuration registers.
    logic [MS_W-1:0]   r_decay_ivl;
    logic [MS_W-1:0]   r_peak_hold;
    logic [STEP_W-1:0] r_decay_step;

    // Channel state memory, one entry per channel, plus valid bits.
    logic [LVL_W-1:0]  r_lvl_mem [CHANNELS];
    logic [LVL_W-1:0]  r_pk_mem  [CHANNELS];
    logic [TIME_W-1:0] r_lt_mem  [CHANNELS];
    logic [TIME_W-1:0] r_pt_mem  [CHANNELS];
    logic [CHANNELS-1:0] r_lvl_ok;
    logic [CHANNELS-1:0] r_pk_ok;

    // Registered read port.
    logic [LVL_W-1:0]  r_rd_lvl;
    logic [LVL_W-1:0]  r_rd_pk;
    logic [TIME_W-1:0] r_rd_lt;
    logic [TIME_W-1:0] r_rd_pt;
    logic              r_rd_lok;
    logic              r_rd_pok;
    logic [CH_W-1:0]   r_addr;

    logic [TIME_W-1:0] r_now;
    logic              r_any;

    // Output register.
    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_channel;
    logic [SEGMENTS-1:0] r_lit_mask;
    logic              r_peak_valid;
    logic [SEG_W-1:0]  r_peak_segment;
    logic              r_changed;
    logic              r_last;

    logic              w_ch_ok;
    logic [LVL_W-1:0]  w_sat;
    logic [LVL_W-1:0]  w_lvl;
    logic [LVL_W-1:0]  w_pk;
    logic [TIME_W-1:0] w_lt;
    logic [TIME_W-1:0] w_pt;
    logic [TIME_W-1:0] w_l_age;
    logic [TIME_W-1:0] w_p_age;
    logic              w_dec;
    logic [LVL_W-1:0]  w_nl;
    logic [LVL_W-1:0]  w_l1;
    logic [TIME_W-1:0] w_lt1;
    logic              w_fall;
    logic [LVL_W-1:0]  w_p1;
    logic              w_follow;
    logic [LVL_W-1:0]  w_p2;
    logic [TIME_W-1:0] w_pt2;
    logic [PROD_W-1:0] w_act_p;
    logic [PROD_W-1:0] w_pr_p;
    logic [ACT_W-1:0]  w_act;
    logic [ACT_W-1:0]  w_pr;
    logic [SEGMENTS-1:0] w_mask;
    logic              w_pv;
    logic [SEG_W-1:0]  w_pseg;

    assign w_ch_ok = ({1'b0, i_channel} < (CH_W + 1)'(CHANNELS));
    assign w_sat   = (i_level_in > bmdph_pkg::FULL_SCALE) ? bmdph_pkg::FULL_SCALE
                                                          : i_level_in;

    // Entries never written read as zero.
    assign w_lvl = r_rd_lok ? r_rd_lvl : '0;
    assign w_lt  = r_rd_lok ? r_rd_lt  : '0;
    assign w_pk  = r_rd_pok ? r_rd_pk  : '0;
    assign w_pt  = r_rd_pok ? r_rd_pt  : '0;

    // Decay, peak fall and peak follow for the channel held in the read register.
    assign w_l_age = r_now - w_lt;
    assign w_p_age = r_now - w_pt;
    assign w_dec   = (w_lvl != '0) && (w_l_age > TIME_W'(r_decay_ivl));
    always_comb begin
        w_nl = (w_lvl > r_decay_step) ? (w_lvl - r_decay_step) : '0;
        if (w_nl < bmdph_pkg::CLEAR_BELOW) begin
            w_nl = '0;
        end
    end
    assign w_l1     = w_dec ? w_nl  : w_lvl;
    assign w_lt1    = w_dec ? r_now : w_lt;
    assign w_fall   = (w_pk != '0) && (w_p_age > TIME_W'(r_peak_hold)) && (w_pk > w_l1);
    assign w_p1     = w_fall ? w_l1 : w_pk;
    assign w_follow = (w_p1 < w_l1);
    assign w_p2     = w_follow ? w_l1  : w_p1;
    assign w_pt2    = w_follow ? r_now : w_pt;

    // Display result: segment counts rounded half up.
    assign w_act_p = PROD_W'(w_lvl) * PROD_W'(SEGMENTS) + PROD_W'(bmdph_pkg::ROUND_HALF);
    assign w_pr_p  = PROD_W'(w_pk)  * PROD_W'(SEGMENTS) + PROD_W'(bmdph_pkg::ROUND_HALF);
    assign w_act   = w_act_p[PROD_W-1:bmdph_pkg::FRAC_BITS];
    assign w_pr    = w_pr_p[PROD_W-1:bmdph_pkg::FRAC_BITS];

    always_comb begin
        for (int s = 0; s < SEGMENTS; s++) begin
            w_mask[s] = (ACT_W'(s) < w_act);
        end
    end

    assign w_pv   = (w_pr != '0) &&
                    ({1'b0, w_pk} > ({1'b0, w_lvl} + bmdph_pkg::PEAK_MARGIN));
    assign w_pseg = (w_pr != '0) ? SEG_W'(w_pr - ACT_W'(1)) : '0;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_ivl  <= bmdph_pkg::DEF_DECAY_INTERVAL;
            r_peak_hold  <= bmdph_pkg::DEF_PEAK_HOLD;
            r_decay_step <= bmdph_pkg::DEF_DECAY_STEP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bmdph_pkg::REG_DECAY_INTERVAL: r_decay_ivl  <= i_cfg_data;
                bmdph_pkg::REG_PEAK_HOLD:      r_peak_hold  <= i_cfg_data;
                bmdph_pkg::REG_DECAY_STEP:     r_decay_step <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lvl_wr && w_ch_ok) begin
            r_lvl_mem[i_channel] <= w_sat;
            r_lt_mem[i_channel]  <= i_time_ms;
        end else if (i_cmd.upd_wr) begin
            r_lvl_mem[r_addr] <= w_l1;
            r_lt_mem[r_addr]  <= w_lt1;
            r_pk_mem[r_addr]  <= w_p2;
            r_pt_mem[r_addr]  <= w_pt2;
        end
    end

    // Memory read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_lvl <= r_lvl_mem[i_idx];
            r_rd_lt  <= r_lt_mem[i_idx];
            r_rd_pk  <= r_pk_mem[i_idx];
            r_rd_pt  <= r_pt_mem[i_idx];
            r_rd_lok <= r_lvl_ok[i_idx];
            r_rd_pok <= r_pk_ok[i_idx];
            r_addr   <= i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_ok <= '0;
            r_pk_ok  <= '0;
        end else if (i_cmd.lvl_wr && w_ch_ok) begin
            r_lvl_ok[i_channel] <= 1'b1;
        end else if (i_cmd.upd_wr) begin
            r_lvl_ok[r_addr] <= 1'b1;
            r_pk_ok[r_addr]  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_now <= i_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (i_cmd.tick_start) begin
            r_any <= 1'b0;
        end else if (i_cmd.upd_wr) begin
            r_any <= r_any | w_dec | w_fall | w_follow;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_channel  <= r_addr;
            r_lit_mask     <= w_mask;
            r_peak_valid   <= w_pv;
            r_peak_segment <= w_pseg;
            r_changed      <= r_any;
            r_last         <= (r_addr == CH_W'(CHANNELS - 1));
        end
    end

    assign o_out_free     = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_channel  = r_out_channel;
    assign o_lit_mask     = r_lit_mask;
    assign o_peak_valid   = r_peak_valid;
    assign o_peak_segment = r_peak_segment;
    assign o_changed      = r_changed;
    assign o_last         = r_last;

endmodule

`default_nettype wire

[hdl/bar_meter_decay_peak_hold.sv]
// Level write: accepted while idle, no result; the next item is taken in the following cycle.
// Tick: an update pass over all channels (read, then write back, through one memory port),
// then a display pass that reads each channel again and loads its result into the output
// register whenever it is free; no new item is taken until the tick's last result is loaded.
// Reset: synchronous, active low; registers return to their defaults and all channel state
// reads as zero at once through per-entry valid bits, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bar_meter_decay_peak_hold #(
    parameter int CHANNELS = bmdph_pkg::DEF_CHANNELS,
    parameter int SEGMENTS = bmdph_pkg::DEF_SEGMENTS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // Configuration write port.
    input  wire                                   i_cfg_wr_en,
    input  wire [bmdph_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [bmdph_pkg::CFG_W-1:0]            i_cfg_data,
    // Input channel.
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire                                   i_opcode,
    input  wire [bmdph_pkg::TIME_W-1:0]           i_time_ms,
    input  wire [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_channel,
    input  wire [bmdph_pkg::LVL_W-1:0]            i_level_in,
    // Result channel.
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] o_out_channel,
    output logic [SEGMENTS-1:0]                   o_lit_mask,
    output logic                                  o_peak_valid,
    output logic [$clog2(SEGMENTS)-1:0]           o_peak_segment,
    output logic                                  o_changed,
    output logic                                  o_last
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // The controller walks the channels twice per tick. The first pass reads each
    // channel's level, peak and their timestamps, applies decay, peak fall and peak
    // follow, and writes the entry back; the change flag collects over the whole
    // pass. Only then does the second pass read each channel again and build its
    // display result, since every result of a tick carries the same change flag.
    bmdph_pkg::t_cmd w_cmd;
    logic [CH_W-1:0] w_idx;
    logic            w_out_free;

    // Sequencer: accepts transfers only when idle, so a level write can never land
    // in the middle of a tick. A finished result may still sit in the output
    // register while the next item is being accepted.
    bmdph_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    // Datapath: configuration registers, the per-channel state memory with its
    // registered read port, the update arithmetic, the segment rounding and the
    // output register that decouples the result transfer from the sequencer.
    bmdph_dp #(
        .CHANNELS (CHANNELS),
        .SEGMENTS (SEGMENTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_idx          (w_idx),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_time_ms      (i_time_ms),
        .i_channel      (i_channel),
        .i_level_in     (i_level_in),
        .o_out_free     (w_out_free),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_channel  (o_out_channel),
        .o_lit_mask     (o_lit_mask),
        .o_peak_valid   (o_peak_valid),
        .o_peak_segment (o_peak_segment),
        .o_changed      (o_changed),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[test/bar_meter_decay_peak_hold_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the eight-channel bar meter. Items go in on the
// input channel, every display result is checked against a behavioural
// predictor kept in step with the block, and both sides idle at random.
module bar_meter_decay_peak_hold_test;

    localparam int CHANNELS  = bmdph_pkg::DEF_CHANNELS;
    localparam int SEGMENTS  = bmdph_pkg::DEF_SEGMENTS;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int SEG_W     = $clog2(SEGMENTS);
    localparam int CFG_IDX_W = bmdph_pkg::CFG_IDX_W;
    localparam int CFG_W     = bmdph_pkg::CFG_W;
    localparam int TIME_W    = bmdph_pkg::TIME_W;
    localparam int LVL_W     = bmdph_pkg::LVL_W;
    localparam int MS_W      = bmdph_pkg::MS_W;
    localparam int STEP_W    = bmdph_pkg::STEP_W;

    // Index 3 is not decoded by the block, so a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // The quiet time allowed after the last result before the block is treated as idle.
    localparam int TICK_DRAIN = 4 * CHANNELS + 8;
    // Length of the long receiver hold-off, in clock cycles.
    localparam int LONG_HOLD  = 400;
    // Hard stop for the whole run, far beyond the slowest correct run.
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_WRITE,
        ROW_CFG
    } t_kind;

    // One display result as the block presents it.
    typedef struct packed {
        logic [CH_W-1:0]     chan;
        logic [SEGMENTS-1:0] mask;
        logic                pv;
        logic [SEG_W-1:0]    seg;
        logic                chg;
        logic                last;
    } t_bar;

    // One row of stimulus. For a register write, value carries the data and
    // reg_idx the register; a pinned row carries a hand-typed result for one
    // channel which replaces the predicted one.
    typedef struct packed {
        t_kind                kind;
        logic [TIME_W-1:0]    at_ms;
        logic [CH_W-1:0]      chan;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     value;
        logic                 pinned;
        t_bar                 pin;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_opcode;
    logic [TIME_W-1:0]    i_time_ms;
    logic [CH_W-1:0]      i_channel;
    logic [LVL_W-1:0]     i_level_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [CH_W-1:0]      o_out_channel;
    logic [SEGMENTS-1:0]  o_lit_mask;
    logic                 o_peak_valid;
    logic [SEG_W-1:0]     o_peak_segment;
    logic                 o_changed;
    logic                 o_last;

    bar_meter_decay_peak_hold #(
        .CHANNELS(CHANNELS),
        .SEGMENTS(SEGMENTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_time_ms     (i_time_ms),
        .i_channel     (i_channel),
        .i_level_in    (i_level_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_channel (o_out_channel),
        .o_lit_mask    (o_lit_mask),
        .o_peak_valid  (o_peak_valid),
        .o_peak_segment(o_peak_segment),
        .o_changed     (o_changed),
        .o_last        (o_last)
    );

    // Predicted meter state: levels and peaks with the time each was last set,
    // plus the three registers as the block should hold them.
    logic [LVL_W-1:0]  lvl_st [CHANNELS];
    logic [LVL_W-1:0]  pk_st  [CHANNELS];
    logic [TIME_W-1:0] lvl_at [CHANNELS];
    logic [TIME_W-1:0] pk_at  [CHANNELS];
    logic [MS_W-1:0]   decay_ivl;
    logic [MS_W-1:0]   hold_ms;
    logic [STEP_W-1:0] step_amt;

    t_bar expected_bars[$];
    t_row dir_rows[$];

    int  n_fail;
    int  n_writes;
    int  n_ticks;
    int  n_bars;
    int  n_cfg;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  long_hold_pending;
    logic [TIME_W-1:0] now_ms;

    // The clock: 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Number of lit segments for a level, with halves rounded up.
    function automatic int seg_count(logic [LVL_W-1:0] v);
        return (int'(v) * SEGMENTS + bmdph_pkg::ROUND_HALF) >> bmdph_pkg::FRAC_BITS;
    endfunction

    function automatic t_row mk(t_kind k, logic [TIME_W-1:0] at, int sel, int val,
                                int pin_ch = -1, int pmask = 0, int ppv = 0,
                                int pseg = 0, int pchg = 0);
        t_row r;
        r          = '0;
        r.kind     = k;
        r.at_ms    = at;
        r.chan     = CH_W'(sel);
        r.reg_idx  = CFG_IDX_W'(sel);
        r.value    = CFG_W'(val);
        r.pinned   = (pin_ch >= 0);
        r.pin.chan = CH_W'(pin_ch);
        r.pin.mask = SEGMENTS'(pmask);
        r.pin.pv   = ppv[0];
        r.pin.seg  = SEG_W'(pseg);
        r.pin.chg  = pchg[0];
        return r;
    endfunction

    // Brings the predicted state up to date for one accepted item. A level
    // write only stores; a tick ages every channel in order and then queues
    // one display result per channel.
    task automatic update_meter(input t_row r);
        logic [TIME_W-1:0] age;
        logic [LVL_W-1:0]  nl;
        bit                any;
        t_bar              b;
        int                act;
        int                pr;
        if (r.kind == ROW_WRITE) begin
            lvl_st[r.chan] = (r.value[LVL_W-1:0] > bmdph_pkg::FULL_SCALE)
                             ? bmdph_pkg::FULL_SCALE : r.value[LVL_W-1:0];
            lvl_at[r.chan] = r.at_ms;
            n_writes++;
        end else begin
            any = 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                // Ages are taken modulo 2^32, so a wrapped clock still ages.
                age = r.at_ms - lvl_at[i];
                if (lvl_st[i] != '0 && age > TIME_W'(decay_ivl)) begin
                    nl = (lvl_st[i] > step_amt) ? lvl_st[i] - step_amt : '0;
                    if (nl < bmdph_pkg::CLEAR_BELOW) begin
                        nl = '0;
                    end
                    lvl_st[i] = nl;
                    lvl_at[i] = r.at_ms;
                    any = 1'b1;
                end
                age = r.at_ms - pk_at[i];
                if (pk_st[i] != '0 && age > TIME_W'(hold_ms) && pk_st[i] > lvl_st[i]) begin
                    pk_st[i] = lvl_st[i];
                    any = 1'b1;
                end
                if (pk_st[i] < lvl_st[i]) begin
                    pk_st[i] = lvl_st[i];
                    pk_at[i] = r.at_ms;
                    any = 1'b1;
                end
            end
            for (int i = 0; i < CHANNELS; i++) begin
                act    = seg_count(lvl_st[i]);
                pr     = seg_count(pk_st[i]);
                b      = '0;
                b.chan = CH_W'(i);
                for (int s = 0; s < SEGMENTS; s++) begin
                    if (s < act) begin
                        b.mask[s] = 1'b1;
                    end
                end
                // A peak that rounds below the first segment shows nothing.
                if (pr >= 1) begin
                    b.seg = SEG_W'(pr - 1);
                    b.pv  = ({1'b0, pk_st[i]} > {1'b0, lvl_st[i]} + bmdph_pkg::PEAK_MARGIN);
                end
                b.chg  = any;
                b.last = (i == CHANNELS - 1);
                expected_bars.push_back(b);
            end
            n_ticks++;
        end
    endtask

    // Offers one item, idling beforehand at the current rate, and waits for
    // the transfer. Valid is left high afterwards so that back-to-back items
    // need no gap; the next call or settle_idle decides what happens to it.
    task automatic send_item(input t_row r);
        int idx;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= (r.kind == ROW_WRITE) ? bmdph_pkg::OP_WRITE : bmdph_pkg::OP_TICK;
        i_time_ms  <= r.at_ms;
        i_channel  <= r.chan;
        i_level_in <= r.value[LVL_W-1:0];
        do @(posedge i_clk); while (o_in_stall);
        update_meter(r);
        if (r.pinned && r.kind == ROW_TICK) begin
            idx = expected_bars.size() - CHANNELS + int'(r.pin.chan);
            expected_bars[idx].mask = r.pin.mask;
            expected_bars[idx].pv   = r.pin.pv;
            expected_bars[idx].seg  = r.pin.seg;
            expected_bars[idx].chg  = r.pin.chg;
        end
    endtask

    // Stops offering items, waits for every expected result and then lets a
    // tick's worth of cycles pass so that a trailing level write has landed.
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TICK_DRAIN) @(posedge i_clk);
    endtask

    // Register write; only ever called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            bmdph_pkg::REG_DECAY_INTERVAL: decay_ivl = data;
            bmdph_pkg::REG_PEAK_HOLD:      hold_ms   = data;
            bmdph_pkg::REG_DECAY_STEP:     step_amt  = data[STEP_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    // Random items against a moving millisecond clock. Most steps are small
    // against the decay interval so that decays and peak holds both happen,
    // some are long enough to drop held peaks, and a few jump anywhere in the
    // 32-bit range. At item pause_at the receiver is either held off for a
    // long stretch or the sender waits until every result is in.
    task automatic random_burst(input int n_items, input int pause_at, input bit hold_off);
        int   pick;
        int   lv;
        t_kind k;
        for (int n = 0; n < n_items; n++) begin
            if (n == pause_at) begin
                if (hold_off) begin
                    long_hold_pending = 1'b1;
                end else begin
                    settle_idle();
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                now_ms += $urandom_range(0, 2 * int'(decay_ivl) + 2);
            end else if (pick < 90) begin
                now_ms += $urandom_range(0, 300);
            end else if (pick < 98) begin
                now_ms += $urandom_range(0, 3000);
            end else begin
                now_ms = $urandom();
            end
            case ($urandom_range(0, 5))
                0:       lv = 0;
                1:       lv = int'(bmdph_pkg::FULL_SCALE);
                2:       lv = $urandom_range(int'(bmdph_pkg::FULL_SCALE) + 1, 8191);
                3:       lv = $urandom_range(0, 80);
                default: lv = $urandom_range(1, int'(bmdph_pkg::FULL_SCALE));
            endcase
            k = ($urandom_range(0, 99) < 45) ? ROW_TICK : ROW_WRITE;
            send_item(mk(k, now_ms, $urandom_range(0, CHANNELS - 1), lv));
        end
    endtask

    function automatic void check_field(string what, int ch, int unsigned want,
                                        int unsigned got);
        if (want != got) begin
            $display("%0t: channel %0d %s expected %0d, actual %0d", $time, ch, what,
                     want, got);
            n_fail++;
        end
    endfunction

    // Result checker: every transfer on the result channel is compared with
    // the oldest expectation, field by field.
    always @(posedge i_clk) begin : result_check
        t_bar want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bars.size() == 0) begin
                $display("%0t: expected nothing, actual result for channel %0d", $time,
                         o_out_channel);
                n_fail++;
            end else begin
                want = expected_bars.pop_front();
                check_field("out_channel", want.chan, want.chan, o_out_channel);
                check_field("lit_mask", want.chan, want.mask, o_lit_mask);
                check_field("peak_valid", want.chan, want.pv, o_peak_valid);
                check_field("peak_segment", want.chan, want.seg, o_peak_segment);
                check_field("changed", want.chan, want.chg, o_changed);
                check_field("last", want.chan, want.last, o_last);
                n_bars++;
            end
        end
    end

    // Receiver: stalls at the current random rate, and when asked holds off
    // without a break for the long hold-off so that the block backs up into its input.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Safety net: a hung handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Run timed out with %0d results outstanding", expected_bars.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_opcode       = bmdph_pkg::OP_TICK;
        i_time_ms      = '0;
        i_channel      = '0;
        i_level_in     = '0;
        n_fail         = 0;
        n_writes       = 0;
        n_ticks        = 0;
        n_bars         = 0;
        n_cfg          = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_pending = 1'b0;
        now_ms         = '0;
        decay_ivl      = bmdph_pkg::DEF_DECAY_INTERVAL;
        hold_ms        = bmdph_pkg::DEF_PEAK_HOLD;
        step_amt       = bmdph_pkg::DEF_DECAY_STEP;
        for (int i = 0; i < CHANNELS; i++) begin
            lvl_st[i] = '0;
            pk_st[i]  = '0;
            lvl_at[i] = '0;
            pk_at[i]  = '0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Hand-typed results sit on rows whose outcome for
        // one channel is obvious; everything else is left to the predictor.
        // A tick straight after reset must show an empty, unchanged meter.
        dir_rows.push_back(mk(ROW_TICK, 0, 0, 0, 0, 'h000, 0, 0, 0));
        // A level above full scale is saturated.
        dir_rows.push_back(mk(ROW_WRITE, 10, 0, 8191));
        dir_rows.push_back(mk(ROW_WRITE, 10, 7, 4096));
        // This one is below the clearing threshold once it decays.
        dir_rows.push_back(mk(ROW_WRITE, 10, 1, 40));
        // This peak rounds below the first segment after its level decays.
        dir_rows.push_back(mk(ROW_WRITE, 10, 5, 170));
        dir_rows.push_back(mk(ROW_TICK, 20, 0, 0, 0, 'hFFF, 0, 11, 1));
        dir_rows.push_back(mk(ROW_WRITE, 30, 2, 2048));
        // First decay: full scale drops one step, the peak is still held.
        dir_rows.push_back(mk(ROW_TICK, 111, 0, 0, 0, 'h7FF, 1, 11, 1));
        dir_rows.push_back(mk(ROW_TICK, 111, 0, 0));
        dir_rows.push_back(mk(ROW_CFG, 0, REG_UNUSED, 'hFFFF));
        // Upper data bits are dropped, leaving a step of zero: levels stay
        // but their times still move and the tick still counts as a change.
        dir_rows.push_back(mk(ROW_CFG, 0, bmdph_pkg::REG_DECAY_STEP, 'hE000));
        dir_rows.push_back(mk(ROW_TICK, 300, 0, 0));
        // A step larger than any level empties the channel in one go.
        dir_rows.push_back(mk(ROW_CFG, 0, bmdph_pkg::REG_DECAY_STEP, 4096));
        dir_rows.push_back(mk(ROW_TICK, 500, 0, 0, 0, 'h000, 1, 11, 1));
        dir_rows.push_back(mk(ROW_CFG, 0, bmdph_pkg::REG_DECAY_STEP, 341));
        dir_rows.push_back(mk(ROW_CFG, 0, bmdph_pkg::REG_PEAK_HOLD, 1));
        // With a one millisecond hold the peak falls straight to the level.
        dir_rows.push_back(mk(ROW_TICK, 510, 0, 0, 0, 'h000, 0, 0, 1));
        // Ages across the wrap of the millisecond clock.
        dir_rows.push_back(mk(ROW_WRITE, 'hFFFF_FFF0, 3, 4095));
        dir_rows.push_back(mk(ROW_TICK, 'hFFFF_FFF8, 0, 0));
        dir_rows.push_back(mk(ROW_TICK, 'h64, 0, 0, 3, 'h7FF, 0, 10, 1));
        dir_rows.push_back(mk(ROW_CFG, 0, bmdph_pkg::REG_DECAY_INTERVAL, 0));
        dir_rows.push_back(mk(ROW_CFG, 0, bmdph_pkg::REG_PEAK_HOLD, 'hFFFF));
        dir_rows.push_back(mk(ROW_WRITE, 200, 6, 1));
        dir_rows.push_back(mk(ROW_WRITE, 200, 4, 4096));
        dir_rows.push_back(mk(ROW_TICK, 201, 0, 0));
        dir_rows.push_back(mk(ROW_CFG, 0, bmdph_pkg::REG_DECAY_STEP, 'h1FFF));
        dir_rows.push_back(mk(ROW_TICK, 400, 0, 0));
        dir_rows.push_back(mk(ROW_CFG, 0, bmdph_pkg::REG_DECAY_INTERVAL, 'hFFFF));

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_CFG) begin
                settle_idle();
                write_reg(dir_rows[n].reg_idx, dir_rows[n].value);
            end else begin
                send_item(dir_rows[n]);
            end
        end
        settle_idle();

        // First random phase: a short decay interval and hold, the sender
        // idling less than the receiver, and one long receiver hold-off.
        write_reg(bmdph_pkg::REG_DECAY_INTERVAL, CFG_W'(25));
        write_reg(bmdph_pkg::REG_PEAK_HOLD, CFG_W'(300));
        write_reg(bmdph_pkg::REG_DECAY_STEP, CFG_W'(341));
        now_ms         = 1000;
        send_idle_pct  = 23;
        recv_stall_pct = 48;
        random_burst(130, 40, 1'b1);
        settle_idle();

        // Second phase: very fast decay with a random step, roles of the two
        // sides reversed, and the sender pausing until everything is in.
        write_reg(bmdph_pkg::REG_DECAY_INTERVAL, CFG_W'(3));
        write_reg(bmdph_pkg::REG_PEAK_HOLD, CFG_W'(60));
        write_reg(bmdph_pkg::REG_DECAY_STEP,
                  CFG_W'($urandom_range(1, int'(bmdph_pkg::FULL_SCALE))));
        send_idle_pct  = 48;
        recv_stall_pct = 23;
        random_burst(130, 60, 1'b0);
        settle_idle();

        // Last phase: reset values written back, no idling on either side.
        write_reg(bmdph_pkg::REG_DECAY_INTERVAL, CFG_W'(bmdph_pkg::DEF_DECAY_INTERVAL));
        write_reg(bmdph_pkg::REG_PEAK_HOLD, CFG_W'(bmdph_pkg::DEF_PEAK_HOLD));
        write_reg(bmdph_pkg::REG_DECAY_STEP, CFG_W'(bmdph_pkg::DEF_DECAY_STEP));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_burst(110, -1, 1'b0);
        settle_idle();

        $display("Run covered %0d level writes, %0d ticks, %0d display results and %0d %s",
                 n_writes, n_ticks, n_bars, n_cfg, "register writes over four settings.");
        $display("Idling went 23/48, 48/23 and 0/0; one %0d-cycle receiver hold-off.",
                 LONG_HOLD);
        if (n_fail == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[bar_meter_decay_peak_hold.f]
hdl/bmdph_pkg.sv
hdl/bmdph_ctrl.sv
hdl/bmdph_dp.sv
hdl/bar_meter_decay_peak_hold.sv
test/bar_meter_decay_peak_hold_test.sv
